FILE: src/integer_to_radix_string_defines.svh
// Shared assertion macros for the integer to radix string block.
`ifndef INTEGER_TO_RADIX_STRING_DEFINES_SVH
`define INTEGER_TO_RADIX_STRING_DEFINES_SVH

// Assert that a property holds at every clock edge outside reset.
`define I2RS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assert that an antecedent on one edge implies a consequent on the next edge.
`define I2RS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/i2rs_pkg.sv
package i2rs_pkg;

  typedef enum logic [1:0] {
    RADIX_OCT = 2'd0,
    RADIX_DEC = 2'd1,
    RADIX_HEX = 2'd2,
    RADIX_HX3 = 2'd3
  } radix_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIGITS,
    BK_EMIT
  } back_state_e;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharX     = 8'h78;
  localparam logic [7:0] CharMinus = 8'h2d;
  localparam logic [7:0] CharPlus  = 8'h2b;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [3:0] DecBase   = 4'd10;

  // Classified conversion job handed from front to back (64-bit magnitude max).
  typedef struct packed {
    logic [63:0] mag;
    logic [1:0]  radix;
    logic        upper;
    logic        zero_alt;   // zero value with alternate form: only zeros
    logic [1:0]  plen;
    logic [7:0]  pre0;
    logic [7:0]  pre1;
    logic [7:0]  digits;     // minimum digit count, never below zero
    logic [7:0]  pad_to;     // minimum digit count from zero padding
  } job_t;

  function automatic logic [7:0] radix_digit_ascii(input logic [3:0] d, input logic up);
    logic [7:0] r;
    if (d < DecBase) r = CharZero + {4'd0, d};
    else r = (up ? CharUpA : CharLowA) + {4'd0, d - DecBase};
    return r;
  endfunction

endpackage

FILE: src/i2rs_front.sv
module i2rs_front #(
  parameter int MAX_CHARS  = 64,
  parameter int VALUE_BITS = 64
) (
  input  logic [63:0]        value_bits_i,
  input  logic               is_signed_i,
  input  logic [1:0]         radix_select_i,
  input  logic               upper_case_i,
  input  logic               alternate_form_i,
  input  logic               zero_pad_i,
  input  logic               plus_sign_i,
  input  logic               space_sign_i,
  input  logic [6:0]         field_width_i,
  input  logic signed [6:0]  precision_i,
  output i2rs_pkg::job_t     job_o
);

  localparam logic [7:0] MaxW = 8'(MAX_CHARS);
  localparam logic [7:0] MaxP = 8'(MAX_CHARS - 2);

  logic [VALUE_BITS-1:0] v;
  logic [7:0] w, pr, dg;
  logic       zp, neg, alt, is_oct, is_hex;
  logic [1:0] plen;

  always_comb begin
    v      = value_bits_i[VALUE_BITS-1:0];
    is_oct = (radix_select_i == i2rs_pkg::RADIX_OCT);
    is_hex = (radix_select_i == i2rs_pkg::RADIX_HEX) || (radix_select_i == i2rs_pkg::RADIX_HX3);
    alt    = alternate_form_i;
    w      = ({1'b0, field_width_i} > MaxW) ? MaxW : {1'b0, field_width_i};
    pr     = {1'b0, precision_i};
    zp     = zero_pad_i;
    dg     = 8'd1;
    if (!precision_i[6]) begin
      dg = (pr > MaxP) ? MaxP : pr;
      zp = 1'b0;
    end
    neg = is_signed_i && v[VALUE_BITS-1];
    job_o = '0;
    job_o.radix = radix_select_i;
    job_o.upper = upper_case_i;
    job_o.mag   = 64'(v);
    job_o.zero_alt = (v == '0) && alt;
    plen = 2'd0;
    if (job_o.zero_alt) begin
      if (dg == 8'd0 && is_oct) dg = 8'd1;
    end else if (is_signed_i) begin
      if (neg) begin
        job_o.mag = 64'((~v) + 1'b1);
        job_o.pre0 = i2rs_pkg::CharMinus; plen = 2'd1;
      end else if (plus_sign_i) begin
        job_o.pre0 = i2rs_pkg::CharPlus; plen = 2'd1;
      end else if (space_sign_i) begin
        job_o.pre0 = i2rs_pkg::CharSpace; plen = 2'd1;
      end
    end else if (alt && is_oct) begin
      job_o.pre0 = i2rs_pkg::CharZero; plen = 2'd1;
      // hold at zero: a count below zero asks for no extra digits either
      if (dg != 8'd0) dg = dg - 8'd1;
    end else if (alt && is_hex) begin
      job_o.pre0 = i2rs_pkg::CharZero;
      job_o.pre1 = i2rs_pkg::CharX; plen = 2'd2;
    end
    job_o.plen   = plen;
    job_o.digits = dg;
    job_o.pad_to = (zp && (w > {6'd0, plen})) ? (w - {6'd0, plen}) : 8'd0;
  end

endmodule

FILE: src/i2rs_queue.sv
module i2rs_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [WIDTH-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WIDTH-1:0] out_data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wp_q, rp_q;
  logic [1:0]       cnt_q;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) mem_q[wp_q] <= in_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (in_valid_i && in_ready_o) wp_q <= ~wp_q;
      if (out_valid_o && out_ready_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(in_valid_i && in_ready_o) - 2'(out_valid_o && out_ready_i);
    end
  end

endmodule

FILE: src/i2rs_back.sv
module i2rs_back #(
  parameter int MAX_CHARS = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            job_valid_i,
  output logic            job_ready_o,
  input  i2rs_pkg::job_t  job_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_char_o,
  output logic            last_char_o,
  output logic            empty_result_o
);

  localparam int            CW      = $clog2(MAX_CHARS + 1);
  localparam logic [CW-1:0] MaxN    = CW'(MAX_CHARS);
  localparam logic [39:0]   Recip10 = 40'd838861;  // ceil(2^23 / 10)

  i2rs_pkg::back_state_e st_q, st_d;
  i2rs_pkg::job_t        job_q;
  logic [63:0]           mag_q;
  logic [63:0]           quo_q;              // decimal quotient, 16 bits per pass
  logic [3:0]            rem_q;              // decimal remainder between passes
  logic [1:0]            chunk_q;            // decimal pass, top chunk first
  logic [3:0]            stk_q [MAX_CHARS];  // digit stack, newest digit in entry 0
  logic [CW-1:0]         nd_q;               // digits produced
  logic [CW-1:0]         tot_q;              // characters to send
  logic [CW-1:0]         pos_q;              // next char index
  logic [15:0]           dec_chunk;
  logic [19:0]           dec_x;
  logic [39:0]           dec_prod;
  logic [15:0]           dec_q;
  logic [19:0]           dec_diff;
  logic [3:0]            dec_r;
  logic [63:0]           dec_quo;
  logic [63:0]           mag_nxt;
  logic [3:0]            dig;
  logic                  busy, more, dec_pass, push, pop;
  logic [7:0]            ch;
  logic [CW:0]           total;

  // Octal and hex take one digit per cycle by shift. Decimal divides by ten in
  // four 16-bit passes, each a reciprocal multiply on remainder and chunk.
  always_comb begin
    unique case (chunk_q)
      2'd0:    dec_chunk = mag_q[63:48];
      2'd1:    dec_chunk = mag_q[47:32];
      2'd2:    dec_chunk = mag_q[31:16];
      default: dec_chunk = mag_q[15:0];
    endcase
    dec_x    = {rem_q, dec_chunk};
    dec_prod = {20'd0, dec_x} * Recip10;
    dec_q    = dec_prod[38:23];
    dec_diff = dec_x - ({1'b0, dec_q, 3'd0} + {3'd0, dec_q, 1'b0});
    dec_r    = dec_diff[3:0];
    dec_quo  = {quo_q[47:0], dec_q};
    unique case (job_q.radix)
      i2rs_pkg::RADIX_OCT: begin mag_nxt = mag_q >> 3; dig = {1'b0, mag_q[2:0]}; end
      i2rs_pkg::RADIX_DEC: begin mag_nxt = dec_quo;    dig = dec_r; end
      default:             begin mag_nxt = mag_q >> 4; dig = mag_q[3:0]; end
    endcase
    // value used up: the rest are precision and padding zeros
    if (mag_q == '0) begin
      mag_nxt = '0;
      dig     = 4'd0;
    end
  end

  always_comb begin
    busy = (st_q == i2rs_pkg::BK_DIGITS) && !job_q.zero_alt;
    more = ((mag_q != '0) || (8'(nd_q) < job_q.digits) || (8'(nd_q) < job_q.pad_to)) &&
           (nd_q < MaxN);
    dec_pass = busy && more && (mag_q != '0) && (job_q.radix == i2rs_pkg::RADIX_DEC) &&
               (chunk_q != 2'd3);
    push = busy && more && !dec_pass;
    pop  = (st_q == i2rs_pkg::BK_EMIT) && out_ready_i && !job_q.zero_alt &&
           (pos_q >= CW'(job_q.plen));
    st_d = st_q;
    unique case (st_q)
      i2rs_pkg::BK_IDLE:   if (job_valid_i) st_d = i2rs_pkg::BK_DIGITS;
      i2rs_pkg::BK_DIGITS: if (!more || job_q.zero_alt) st_d = i2rs_pkg::BK_EMIT;
      i2rs_pkg::BK_EMIT:   if (out_ready_i &&
                               (tot_q == '0 || pos_q == tot_q - 1'b1))
                             st_d = i2rs_pkg::BK_IDLE;
      default:             st_d = i2rs_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    job_ready_o = (st_q == i2rs_pkg::BK_IDLE);
    out_valid_o = (st_q == i2rs_pkg::BK_EMIT);
    if (pos_q < CW'(job_q.plen)) ch = pos_q[0] ? job_q.pre1 : job_q.pre0;
    else if (job_q.zero_alt) ch = i2rs_pkg::CharZero;
    else ch = i2rs_pkg::radix_digit_ascii(stk_q[0], job_q.upper);
    empty_result_o = (tot_q == '0);
    out_char_o     = empty_result_o ? 8'd0 : ch;
    last_char_o    = empty_result_o || (pos_q == tot_q - 1'b1);
    total = job_q.zero_alt ? (CW+1)'(job_q.digits) : (CW+1)'(job_q.plen) + (CW+1)'(nd_q);
  end

  always_ff @(posedge clk_i) begin
    if (st_q == i2rs_pkg::BK_IDLE && job_valid_i) begin
      job_q <= job_i;
      mag_q <= job_i.mag;
      quo_q <= '0;
      rem_q <= '0;
    end else if (dec_pass) begin
      quo_q <= dec_quo;
      rem_q <= dec_r;
    end else if (push) begin
      mag_q <= mag_nxt;
      quo_q <= '0;
      rem_q <= '0;
    end
  end

  // Push the least significant digit first, pop the most significant first.
  always_ff @(posedge clk_i) begin
    if (push) begin
      stk_q[0] <= dig;
      for (int i = 1; i < MAX_CHARS; i++) stk_q[i] <= stk_q[i-1];
    end else if (pop) begin
      for (int i = 0; i < MAX_CHARS - 1; i++) stk_q[i] <= stk_q[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= i2rs_pkg::BK_IDLE; nd_q <= '0; pos_q <= '0; tot_q <= '0; chunk_q <= '0;
    end else begin
      st_q <= st_d;
      if (st_q == i2rs_pkg::BK_IDLE) begin
        nd_q <= '0; pos_q <= '0; chunk_q <= '0;
      end else if (st_q == i2rs_pkg::BK_DIGITS) begin
        if (push) nd_q <= nd_q + 1'b1;
        if (dec_pass) chunk_q <= chunk_q + 1'b1;
        else if (push) chunk_q <= '0;
        if (!more || job_q.zero_alt)
          tot_q <= (total > (CW+1)'(MAX_CHARS)) ? MaxN : CW'(total);
      end else if (st_q == i2rs_pkg::BK_EMIT && out_ready_i) begin
        pos_q <= pos_q + 1'b1;
      end
    end
  end

endmodule

FILE: src/integer_to_radix_string.sv
// Digits: one per shift step for octal or hex, four 16-bit reciprocal passes
//   per decimal digit, one step per zero digit once the value is used up.
// Throughput: one character per cycle out while out_ready_i is high; a two-entry
//   queue lets the front take the next item while the back end is busy.
// Reset: rst_ni asynchronous active low clears queue and back-end control.
module integer_to_radix_string #(
  parameter int MAX_CHARS  = 64,
  parameter int VALUE_BITS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [63:0]        value_bits_i,
  input  logic               is_signed_i,
  input  logic [1:0]         radix_select_i,
  input  logic               upper_case_i,
  input  logic               alternate_form_i,
  input  logic               zero_pad_i,
  input  logic               plus_sign_i,
  input  logic               space_sign_i,
  input  logic [6:0]         field_width_i,
  input  logic signed [6:0]  precision_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         out_char_o,
  output logic               last_char_o,
  output logic               empty_result_o
);

  i2rs_pkg::job_t job_in, job_out;
  logic           q_valid, q_ready;

  // Classify: sign, prefix, digit minimum and padding target.
  i2rs_front #(.MAX_CHARS(MAX_CHARS), .VALUE_BITS(VALUE_BITS)) u_front (
    .value_bits_i, .is_signed_i, .radix_select_i, .upper_case_i, .alternate_form_i,
    .zero_pad_i, .plus_sign_i, .space_sign_i, .field_width_i, .precision_i,
    .job_o(job_in)
  );

  // Hold up to two classified items between the halves.
  i2rs_queue #(.WIDTH($bits(i2rs_pkg::job_t))) u_queue (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(job_in),
    .out_valid_o(q_valid), .out_ready_i(q_ready), .out_data_o(job_out)
  );

  // Generate digits, then stream characters most significant first.
  i2rs_back #(.MAX_CHARS(MAX_CHARS)) u_back (
    .clk_i, .rst_ni,
    .job_valid_i(q_valid), .job_ready_o(q_ready), .job_i(job_out),
    .out_valid_o, .out_ready_i, .out_char_o, .last_char_o, .empty_result_o
  );

endmodule

FILE: src/i2rs_checker.sv
`include "integer_to_radix_string_defines.svh"
module i2rs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_char_o,
  input logic       last_char_o,
  input logic       empty_result_o
);
  `I2RS_ASSERT(a_empty_last, clk_i, rst_ni, !(out_valid_o && empty_result_o) || last_char_o, "empty not last")
  `I2RS_ASSERT(a_empty_zero, clk_i, rst_ni, !(out_valid_o && empty_result_o) || (out_char_o == 8'd0), "empty char")
  `I2RS_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_char_o), "stall")
endmodule

bind integer_to_radix_string i2rs_checker u_chk (.*);

FILE: dv/integer_to_radix_string_test.sv
module integer_to_radix_string_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [63:0]       value;
    logic              sgn;
    logic [1:0]        radix;
    logic              upper;
    logic              alt;
    logic              zpad;
    logic              plus;
    logic              space;
    logic [6:0]        width;
    logic signed [6:0] prec;
  } conv_req_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
    logic       empty;
  } conv_char_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [63:0]       value_bits_i;
  logic              is_signed_i;
  logic [1:0]        radix_select_i;
  logic              upper_case_i;
  logic              alternate_form_i;
  logic              zero_pad_i;
  logic              plus_sign_i;
  logic              space_sign_i;
  logic [6:0]        field_width_i;
  logic signed [6:0] precision_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [7:0]        out_char_o;
  logic              last_char_o;
  logic              empty_result_o;

  conv_req_t  pending_reqs[$];
  conv_char_t expected_chars[$];
  int         mismatches = 0;
  int         chars_seen = 0;
  int         reqs_sent = 0;
  int         reqs_total = 0;
  logic       stim_done;
  logic       hold_off;
  logic       in_took;
  int         in_gap;
  int         out_gap;

  integer_to_radix_string i_dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Short gaps are common, long ones rare.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 70);
  endfunction

  function automatic logic [7:0] hex_digit(int d, logic up);
    if (d < 10) return i2rs_pkg::CharZero + 8'(d);
    return (up ? i2rs_pkg::CharUpA : i2rs_pkg::CharLowA) + 8'(d - 10);
  endfunction

  // Build the character string of one conversion and queue it up.
  task automatic predict_conversion(input conv_req_t r);
    logic [7:0]  text[$];
    logic [7:0]  prefix[$];
    logic [7:0]  rdig[$];
    logic [63:0] mag;
    int          base;
    int          ndig;
    int          w;
    int          pad;
    logic        zp;
    conv_char_t  c;
    base = (r.radix == i2rs_pkg::RADIX_OCT) ? 8 : (r.radix == i2rs_pkg::RADIX_DEC) ? 10 : 16;
    w = (r.width > 64) ? 64 : int'(r.width);
    zp = r.zpad;
    ndig = 1;
    if (!r.prec[6]) begin
      ndig = (r.prec > 62) ? 62 : int'(r.prec);
      zp = 1'b0;
    end
    if (r.value == 0 && r.alt) begin
      // zero with alternate form: only zeros, octal never empties
      if (ndig == 0 && base == 8) ndig = 1;
      repeat (ndig) text.push_back(i2rs_pkg::CharZero);
    end else begin
      mag = r.value;
      if (r.sgn) begin
        if (r.value[63]) begin
          mag = -r.value;
          prefix.push_back(i2rs_pkg::CharMinus);
        end else if (r.plus) prefix.push_back(i2rs_pkg::CharPlus);
        else if (r.space) prefix.push_back(i2rs_pkg::CharSpace);
      end else if (r.alt && base == 8) begin
        prefix.push_back(i2rs_pkg::CharZero);
        ndig--;
      end else if (r.alt && base == 16) begin
        prefix.push_back(i2rs_pkg::CharZero);
        prefix.push_back(i2rs_pkg::CharX);
      end
      while ((mag != 0 || rdig.size() < ndig) && rdig.size() < 64) begin
        rdig.push_back(hex_digit(int'(mag % base), r.upper));
        mag = mag / base;
      end
      if (zp) begin
        pad = w - prefix.size();
        while (rdig.size() < pad && rdig.size() < 64) rdig.push_back(i2rs_pkg::CharZero);
      end
      foreach (prefix[i]) text.push_back(prefix[i]);
      for (int i = rdig.size() - 1; i >= 0 && text.size() < 64; i--)
        text.push_back(rdig[i]);
    end
    if (text.size() == 0) begin
      c.ch = 8'h00;
      c.last = 1'b1;
      c.empty = 1'b1;
      expected_chars.push_back(c);
    end else begin
      foreach (text[i]) begin
        c.ch = text[i];
        c.last = (i == text.size() - 1);
        c.empty = 1'b0;
        expected_chars.push_back(c);
      end
    end
  endtask

  function automatic conv_req_t random_req();
    conv_req_t r;
    int k;
    k = $urandom_range(0, 9);
    r.value = {$urandom, $urandom};
    if (k == 0) r.value = 0;
    else if (k == 1) r.value = 64'(1) << $urandom_range(0, 63);
    else if (k == 2) r.value = -(64'($urandom_range(0, 20)));
    else if (k == 3) r.value = 64'($urandom_range(0, 999));
    r.sgn = 1'($urandom);
    r.radix = 2'($urandom);
    r.upper = 1'($urandom);
    r.alt = 1'($urandom);
    r.zpad = 1'($urandom);
    r.plus = 1'($urandom);
    r.space = 1'($urandom);
    r.width = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(0, 24));
    k = $urandom_range(0, 9);
    if (k < 4) r.prec = -7'sd1;
    else if (k < 5) r.prec = 7'($urandom);
    else r.prec = 7'($urandom_range(0, 20));
    return r;
  endfunction

  function automatic conv_req_t make_req(logic [63:0] v, logic s, logic [1:0] rad,
                                         logic up, logic a, logic z, logic p,
                                         logic sp, logic [6:0] w, logic [6:0] pr);
    conv_req_t r;
    r.value = v; r.sgn = s; r.radix = rad; r.upper = up; r.alt = a;
    r.zpad = z; r.plus = p; r.space = sp; r.width = w; r.prec = pr;
    return r;
  endfunction

  initial begin
    stim_done = 1'b0;
    hold_off = 1'b0;
    // Directed: extremes, each radix, and each quirk of the conversion.
    pending_reqs.push_back(make_req(0, 0, i2rs_pkg::RADIX_DEC, 0, 0, 0, 0, 0, 0, 7'h7f));
    pending_reqs.push_back(make_req(0, 0, i2rs_pkg::RADIX_DEC, 0, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(0, 0, i2rs_pkg::RADIX_HEX, 0, 1, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(0, 0, i2rs_pkg::RADIX_OCT, 0, 1, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(0, 1, i2rs_pkg::RADIX_DEC, 0, 1, 1, 1, 0, 20, 5));
    pending_reqs.push_back(make_req('1, 0, i2rs_pkg::RADIX_OCT, 0, 1, 0, 0, 0, 0, 7'h7f));
    pending_reqs.push_back(make_req('1, 0, i2rs_pkg::RADIX_DEC, 0, 0, 0, 0, 0, 0, 7'h7f));
    pending_reqs.push_back(make_req('1, 0, i2rs_pkg::RADIX_HEX, 1, 1, 0, 0, 0, 0, 7'h7f));
    pending_reqs.push_back(make_req('1, 1, i2rs_pkg::RADIX_HEX, 0, 1, 0, 0, 0, 0, 7'h7f));
    pending_reqs.push_back(make_req(64'h8000_0000_0000_0000, 1, i2rs_pkg::RADIX_DEC,
                                    0, 0, 0, 0, 0, 0, 7'h7f));
    pending_reqs.push_back(make_req(64'h7fff_ffff_ffff_ffff, 1, i2rs_pkg::RADIX_DEC,
                                    0, 0, 0, 1, 0, 0, 7'h7f));
    pending_reqs.push_back(make_req(42, 1, i2rs_pkg::RADIX_DEC, 0, 0, 0, 0, 1, 0, 7'h7f));
    pending_reqs.push_back(make_req(42, 1, i2rs_pkg::RADIX_HEX, 0, 1, 1, 0, 1, 10, 7'h7f));
    pending_reqs.push_back(make_req(64'hdead_beef, 0, i2rs_pkg::RADIX_HX3,
                                    1, 1, 1, 0, 0, 16, 7'h7f));
    pending_reqs.push_back(make_req(64'hdead_beef, 0, i2rs_pkg::RADIX_HEX,
                                    0, 1, 1, 0, 0, 16, 3));
    pending_reqs.push_back(make_req(8, 0, i2rs_pkg::RADIX_OCT, 0, 1, 0, 0, 0, 0, 4));
    pending_reqs.push_back(make_req(1, 0, i2rs_pkg::RADIX_OCT, 0, 1, 1, 0, 0, 7'd127,
                                    7'h7f));
    pending_reqs.push_back(make_req(1, 0, i2rs_pkg::RADIX_DEC, 0, 0, 0, 0, 0, 0, 7'd62));
    pending_reqs.push_back(make_req(1, 1, i2rs_pkg::RADIX_DEC, 0, 0, 0, 1, 0, 0, 7'd63));
    pending_reqs.push_back(make_req(5, 0, i2rs_pkg::RADIX_DEC, 0, 0, 0, 0, 0, 0, 7'h50));
    pending_reqs.push_back(make_req('1, 1, i2rs_pkg::RADIX_OCT, 0, 0, 1, 0, 0, 7'd64,
                                    7'h7f));
    pending_reqs.push_back(make_req(64'h5555_aaaa_5555_aaaa, 0, i2rs_pkg::RADIX_OCT,
                                    0, 0, 0, 0, 0, 0, 7'h7f));
    repeat (50) pending_reqs.push_back(random_req());
    reqs_total = pending_reqs.size();
    wait (reqs_sent == reqs_total);
    // Let the block drain completely before the second half.
    hold_off = 1'b1;
    wait (expected_chars.size() == 0);
    @(negedge clk_i);
    hold_off = 1'b0;
    repeat (50) pending_reqs.push_back(random_req());
    reqs_total = reqs_total + 50;
    wait (reqs_sent == reqs_total);
    stim_done = 1'b1;
  end

  // Driver: present one item at a time, hold it until accepted.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_gap <= 0;
      value_bits_i <= '0;
      is_signed_i <= 1'b0;
      radix_select_i <= i2rs_pkg::RADIX_OCT;
      upper_case_i <= 1'b0;
      alternate_form_i <= 1'b0;
      zero_pad_i <= 1'b0;
      plus_sign_i <= 1'b0;
      space_sign_i <= 1'b0;
      field_width_i <= '0;
      precision_i <= '0;
    end else if (in_valid_i && in_took) begin
      in_valid_i <= 1'b0;
      in_gap <= pick_gap();
    end else if (!in_valid_i) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
      end else if (!hold_off && pending_reqs.size() > 0) begin
        conv_req_t r;
        r = pending_reqs.pop_front();
        value_bits_i <= r.value;
        is_signed_i <= r.sgn;
        radix_select_i <= r.radix;
        upper_case_i <= r.upper;
        alternate_form_i <= r.alt;
        zero_pad_i <= r.zpad;
        plus_sign_i <= r.plus;
        space_sign_i <= r.space;
        field_width_i <= r.width;
        precision_i <= r.prec;
        in_valid_i <= 1'b1;
      end
    end
  end

  // Sink side: random back-pressure.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_gap <= 0;
    end else if (out_gap > 0) begin
      out_ready_i <= 1'b0;
      out_gap <= out_gap - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ready_i <= 1'b0;
      out_gap <= pick_gap();
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Monitor: predict on accept, compare every character taken.
  always @(posedge clk_i) begin
    in_took <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) begin
      conv_req_t r;
      r = make_req(value_bits_i, is_signed_i, radix_select_i, upper_case_i,
                   alternate_form_i, zero_pad_i, plus_sign_i, space_sign_i,
                   field_width_i, precision_i);
      predict_conversion(r);
      reqs_sent++;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      conv_char_t e;
      chars_seen++;
      if (expected_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected char %h last %b empty %b", out_char_o, last_char_o,
                   empty_result_o);
      end else begin
        e = expected_chars.pop_front();
        if (e.ch !== out_char_o || e.last !== last_char_o || e.empty !== empty_result_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp char %h last %b empty %b, got %h %b %b",
                     e.ch, e.last, e.empty, out_char_o, last_char_o, empty_result_o);
        end
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait (stim_done === 1'b1);
    wait (expected_chars.size() == 0);
    repeat (200) @(posedge clk_i);
    $display("Covered octal, decimal and hex of signed and unsigned values with sign and");
    $display("prefix options, padding and precision bounds, under random stalls and a drain.");
    $display("%0d conversions sent, %0d characters checked, %0d mismatches",
             reqs_sent, chars_seen, mismatches);
    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
